### design/dot_pkg.sv
// Shared types, request codes, register addresses and the timer period table.
`default_nettype none

package dot_pkg;

    // Both prescalers are kept at full width and saturate at the top value.
    localparam int PRESC_W = 16;

    typedef logic [PRESC_W-1:0] presc_t;

    // Result of one prescaler step: the new count and a one-cycle carry.
    typedef struct packed {
        presc_t count;
        logic   carry;
    } presc_step_t;

    // Request type codes.
    localparam logic [1:0] REQ_TICK  = 2'd0;
    localparam logic [1:0] REQ_READ  = 2'd1;
    localparam logic [1:0] REQ_WRITE = 2'd2;

    // Bus register addresses.
    localparam logic [15:0] ADDR_DIV  = 16'hFF04;
    localparam logic [15:0] ADDR_TIMA = 16'hFF05;
    localparam logic [15:0] ADDR_TMA  = 16'hFF06;
    localparam logic [15:0] ADDR_TAC  = 16'hFF07;

    // Control register layout.
    localparam int           TAC_W          = 3;
    localparam int           TAC_ENABLE_BIT = 2;
    localparam logic [7:0]   TAC_MASK       = 8'h07;
    localparam logic [7:0]   READ_UNKNOWN   = 8'hFF;

    // Timer prescaler period selected by control bits 1:0.
    function automatic presc_t timer_period(input logic [1:0] sel);
        presc_t period;
        unique case (sel)
            2'b00: period = presc_t'(1024);
            2'b01: period = presc_t'(16);
            2'b10: period = presc_t'(64);
            2'b11: period = presc_t'(256);
            default: period = presc_t'(1024);
        endcase
        return period;
    endfunction

endpackage

`default_nettype wire

### design/dot_prescaler.sv
// Saturating cycle prescaler that wraps once per step against a given period.
`default_nettype none

module dot_prescaler (
    input  wire logic          enable,
    input  wire dot_pkg::presc_t count,
    input  wire dot_pkg::presc_t period,
    input  wire logic [7:0]    cycles,
    output dot_pkg::presc_step_t step
);
    import dot_pkg::*;

    logic [PRESC_W:0] sum;
    presc_t           sat;

    // Add the spent cycles, clamp at the top value, then subtract one period at most.
    always_comb begin
        sum = {1'b0, count} + (PRESC_W+1)'(cycles);
        sat = sum[PRESC_W] ? '1 : sum[PRESC_W-1:0];
        step.count = count;
        step.carry = 1'b0;
        if (enable) begin
            if (sat >= period) begin
                step.count = sat - period;
                step.carry = 1'b1;
            end else begin
                step.count = sat;
            end
        end
    end

endmodule

`default_nettype wire

### design/divider_and_overflow_timer_core.sv
// Divider and overflow timer: a tick counter pair with a bus register interface.
//
// Usage: each request on the s_ channel is a tick carrying a count of spent
// cycles, a bus read or a bus write of one of the four timer registers.
// Every request produces exactly one result on the m_ channel: the read byte
// (0xFF for an unknown address), the timer interrupt for a tick that made the
// timer wrap and reload, and a flag for an access to an unknown address.
// The request register loads at the accepting edge and the result register at
// the edge on which the request fires, with all state updates done in the
// single pass between them. Throughput is one request per cycle while the
// receiver takes results; the saturating prescaler add and period compare
// lie between those registers.
// When the receiver stalls, the result register holds and the request
// register fills; s_ready drops only when both are occupied, and both refill
// in the same cycle the result is taken. Reset (aresetn low at a clock edge)
// clears all counters, the modulo and control registers, the pending modulo
// write and both valid flags.
`default_nettype none

module divider_and_overflow_timer_core #(
    parameter int DIV_PERIOD = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_req_type,
    input  wire logic [7:0]  s_spent_cycles,
    input  wire logic [15:0] s_address,
    input  wire logic [7:0]  s_write_data,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [7:0]       m_read_data,
    output logic             m_timer_irq,
    output logic             m_bad_address
);
    import dot_pkg::*;

    localparam presc_t DivPeriod = presc_t'(DIV_PERIOD);

    // Request register.
    logic        in_valid_reg;
    logic [1:0]  req_reg;
    logic [7:0]  cycles_reg;
    logic [15:0] addr_reg;
    logic [7:0]  wdata_reg;

    // Result register.
    logic        out_valid_reg;
    logic [7:0]  rdata_reg, rdata_next;
    logic        irq_reg, irq_next;
    logic        bad_reg, bad_next;

    // Timer state.
    presc_t           div_presc_reg, div_presc_next;
    presc_t           tim_presc_reg, tim_presc_next;
    logic [7:0]       div_value_reg, div_value_next;
    logic [7:0]       tim_value_reg, tim_value_next;
    logic [7:0]       modulo_reg, modulo_next;
    logic [TAC_W-1:0] control_reg, control_next;
    logic [7:0]       pend_modulo_reg, pend_modulo_next;
    logic             pend_flag_reg, pend_flag_next;

    logic        out_free;
    logic        fire;
    logic        is_tick;
    presc_step_t div_step;
    presc_step_t tim_step;

    // Handshake: the request register refills whenever the result register can advance.
    assign out_free = !out_valid_reg || m_ready;
    assign s_ready  = !in_valid_reg || out_free;
    assign fire     = in_valid_reg && out_free;
    assign is_tick  = (req_reg == REQ_TICK);

    assign m_valid       = out_valid_reg;
    assign m_read_data   = rdata_reg;
    assign m_timer_irq   = irq_reg;
    assign m_bad_address = bad_reg;

    // Divider prescaler.
    dot_prescaler u_div_presc (
        .enable (is_tick),
        .count  (div_presc_reg),
        .period (DivPeriod),
        .cycles (cycles_reg),
        .step   (div_step)
    );

    // Timer prescaler, running only while the control enable bit is set.
    dot_prescaler u_tim_presc (
        .enable (is_tick && control_reg[TAC_ENABLE_BIT]),
        .count  (tim_presc_reg),
        .period (timer_period(control_reg[1:0])),
        .cycles (cycles_reg),
        .step   (tim_step)
    );

    // Next state and result for the request in the request register.
    always_comb begin
        div_presc_next   = div_presc_reg;
        tim_presc_next   = tim_presc_reg;
        div_value_next   = div_value_reg;
        tim_value_next   = tim_value_reg;
        modulo_next      = modulo_reg;
        control_next     = control_reg;
        pend_modulo_next = pend_modulo_reg;
        pend_flag_next   = pend_flag_reg;
        rdata_next       = 8'd0;
        irq_next         = 1'b0;
        bad_next         = 1'b0;
        unique case (req_reg)
            REQ_TICK: begin
                div_presc_next = div_step.count;
                tim_presc_next = tim_step.count;
                if (div_step.carry) begin
                    div_value_next = div_value_reg + 8'd1;
                end
                // A wrap reloads from the modulo in force before this tick.
                if (tim_step.carry) begin
                    if (tim_value_reg == 8'hFF) begin
                        tim_value_next = modulo_reg;
                        irq_next       = 1'b1;
                    end else begin
                        tim_value_next = tim_value_reg + 8'd1;
                    end
                end
                if (pend_flag_reg) begin
                    modulo_next    = pend_modulo_reg;
                    pend_flag_next = 1'b0;
                end
            end
            REQ_READ: begin
                unique case (addr_reg)
                    ADDR_DIV:  rdata_next = div_value_reg;
                    ADDR_TIMA: rdata_next = tim_value_reg;
                    ADDR_TMA:  rdata_next = modulo_reg;
                    ADDR_TAC:  rdata_next = 8'(control_reg);
                    default: begin
                        rdata_next = READ_UNKNOWN;
                        bad_next   = 1'b1;
                    end
                endcase
            end
            REQ_WRITE: begin
                unique case (addr_reg)
                    ADDR_DIV:  div_value_next = 8'd0;
                    ADDR_TIMA: tim_value_next = wdata_reg;
                    ADDR_TMA: begin
                        pend_modulo_next = wdata_reg;
                        pend_flag_next   = 1'b1;
                    end
                    ADDR_TAC: begin
                        control_next   = TAC_W'(wdata_reg & TAC_MASK);
                        tim_presc_next = '0;
                    end
                    default: bad_next = 1'b1;
                endcase
            end
            default: begin
                // Undefined request type: no state change, all-zero result.
            end
        endcase
    end

    // Control state and valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            div_presc_reg   <= '0;
            tim_presc_reg   <= '0;
            div_value_reg   <= '0;
            tim_value_reg   <= '0;
            modulo_reg      <= '0;
            control_reg     <= '0;
            pend_modulo_reg <= '0;
            pend_flag_reg   <= 1'b0;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
            if (fire) begin
                div_presc_reg   <= div_presc_next;
                tim_presc_reg   <= tim_presc_next;
                div_value_reg   <= div_value_next;
                tim_value_reg   <= tim_value_next;
                modulo_reg      <= modulo_next;
                control_reg     <= control_next;
                pend_modulo_reg <= pend_modulo_next;
                pend_flag_reg   <= pend_flag_next;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            req_reg    <= s_req_type;
            cycles_reg <= s_spent_cycles;
            addr_reg   <= s_address;
            wdata_reg  <= s_write_data;
        end
        if (fire) begin
            rdata_reg <= rdata_next;
            irq_reg   <= irq_next;
            bad_reg   <= bad_next;
        end
    end

    // A result never carries both an interrupt and an address error.
    a_irq_not_bad: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_timer_irq && m_bad_address))
        else $error("timer interrupt together with bad address");

    // An interrupt only comes from a tick, whose read byte is zero.
    a_irq_zero_data: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_timer_irq) |-> (m_read_data == 8'd0))
        else $error("timer interrupt with nonzero read data");

    // A control write clears the timer prescaler.
    a_tac_clears_presc: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && req_reg == REQ_WRITE && addr_reg == ADDR_TAC) |=> (tim_presc_reg == '0))
        else $error("timer prescaler not cleared by control write");

    // Any tick retires a pending modulo write.
    a_tick_retires_modulo: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && is_tick) |=> !pend_flag_reg)
        else $error("pending modulo write survived a tick");

endmodule

`default_nettype wire

### bench/timer_result_checker.sv
// Watches both channels of the divider and overflow timer, predicts each result and compares it.
`timescale 1ns / 100ps

module timer_result_checker #(
    parameter int DIV_PERIOD = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_spent_cycles,
    input  logic [15:0] s_address,
    input  logic [7:0]  s_write_data,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_read_data,
    input  logic        m_timer_irq,
    input  logic        m_bad_address,
    output int          mismatch_count,
    output int          results_owed,
    output int          overflows_seen
);
    import dot_pkg::*;

    // One result as the block should return it.
    typedef struct packed {
        logic [7:0] read_data;
        logic       timer_irq;
        logic       bad_address;
    } timer_result_t;

    // Timer prescaler period for each setting of control bits 1:0.
    localparam int unsigned TIMER_PERIODS [4] = '{1024, 16, 64, 256};
    localparam logic [16:0] PRESC_TOP = 17'h0FFFF;

    // Mirror of the block's state.
    presc_t           div_presc;
    presc_t           timer_presc;
    logic [7:0]       div_count;
    logic [7:0]       timer_count;
    logic [7:0]       modulo;
    logic [TAC_W-1:0] control;
    logic [7:0]       modulo_next;
    logic             modulo_waiting;

    timer_result_t expected_results [$];
    timer_result_t oldest;

    // Adds spent cycles to a prescaler, stopping at the top value.
    function automatic presc_t add_saturating(presc_t count, logic [7:0] cycles);
        logic [16:0] sum;
        sum = {1'b0, count} + 17'(cycles);
        return (sum > PRESC_TOP) ? presc_t'(PRESC_TOP) : sum[15:0];
    endfunction

    // Applies one request to the mirrored state and returns the result it causes.
    function automatic timer_result_t apply_timer_request(logic [1:0] req, logic [7:0] cycles,
                                                          logic [15:0] addr, logic [7:0] data);
        timer_result_t res;
        presc_t        period;
        res = '0;
        case (req)
            REQ_TICK: begin
                div_presc = add_saturating(div_presc, cycles);
                if (div_presc >= presc_t'(DIV_PERIOD)) begin
                    div_presc = div_presc - presc_t'(DIV_PERIOD);
                    div_count = div_count + 8'd1;
                end
                if (control[TAC_ENABLE_BIT]) begin
                    period      = presc_t'(TIMER_PERIODS[control[1:0]]);
                    timer_presc = add_saturating(timer_presc, cycles);
                    if (timer_presc >= period) begin
                        timer_presc = timer_presc - period;
                        timer_count = timer_count + 8'd1;
                        // Wrap to zero reloads from the modulo in force before this tick.
                        if (timer_count == 8'd0) begin
                            res.timer_irq = 1'b1;
                            timer_count   = modulo;
                        end
                    end
                end
                // A held modulo write lands only after any reload of this tick.
                if (modulo_waiting) begin
                    modulo         = modulo_next;
                    modulo_waiting = 1'b0;
                end
            end
            REQ_READ: begin
                case (addr)
                    ADDR_DIV:  res.read_data = div_count;
                    ADDR_TIMA: res.read_data = timer_count;
                    ADDR_TMA:  res.read_data = modulo;
                    ADDR_TAC:  res.read_data = 8'(control);
                    default: begin
                        res.read_data   = READ_UNKNOWN;
                        res.bad_address = 1'b1;
                    end
                endcase
            end
            REQ_WRITE: begin
                case (addr)
                    ADDR_DIV:  div_count = 8'd0;
                    ADDR_TIMA: timer_count = data;
                    ADDR_TMA: begin
                        modulo_next    = data;
                        modulo_waiting = 1'b1;
                    end
                    ADDR_TAC: begin
                        control     = data[TAC_W-1:0];
                        timer_presc = '0;
                    end
                    default: res.bad_address = 1'b1;
                endcase
            end
            default: ;
        endcase
        return res;
    endfunction

    // Compare each result with the oldest prediction, then predict for a new request.
    always @(posedge aclk) begin
        if (!aresetn) begin
            div_presc      = '0;
            timer_presc    = '0;
            div_count      = '0;
            timer_count    = '0;
            modulo         = '0;
            control        = '0;
            modulo_next    = '0;
            modulo_waiting = 1'b0;
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (m_timer_irq) begin
                    overflows_seen = overflows_seen + 1;
                end
                if (expected_results.size() == 0) begin
                    $error("Result arrived with no request outstanding: read_data %0h",
                           m_read_data);
                    mismatch_count = mismatch_count + 1;
                end else begin
                    oldest = expected_results.pop_front();
                    if (m_read_data !== oldest.read_data) begin
                        $error("read_data mismatch: expected %0h, actual %0h",
                               oldest.read_data, m_read_data);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (m_timer_irq !== oldest.timer_irq) begin
                        $error("timer_irq mismatch: expected %0b, actual %0b",
                               oldest.timer_irq, m_timer_irq);
                        mismatch_count = mismatch_count + 1;
                    end
                    if (m_bad_address !== oldest.bad_address) begin
                        $error("bad_address mismatch: expected %0b, actual %0b",
                               oldest.bad_address, m_bad_address);
                        mismatch_count = mismatch_count + 1;
                    end
                end
            end
            if (s_valid && s_ready) begin
                expected_results.push_back(apply_timer_request(s_req_type, s_spent_cycles,
                                                               s_address, s_write_data));
            end
        end
        results_owed = expected_results.size();
    end

    initial begin
        mismatch_count = 0;
        results_owed   = 0;
        overflows_seen = 0;
    end

endmodule

### bench/tb_divider_and_overflow_timer_core.sv
// Stimulus and verdict for the divider and overflow timer core.
`timescale 1ns / 100ps

module tb_divider_and_overflow_timer_core;
    import dot_pkg::*;

    localparam int         DIV_PERIOD   = 256;
    localparam int         RANDOM_ITEMS = 600;
    localparam int         STALL_LIMIT  = 2000;
    localparam int         DRAIN_CYCLES = 8;
    localparam logic [1:0] REQ_UNUSED   = 2'd3;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = REQ_TICK;
    logic [7:0]  s_spent_cycles = '0;
    logic [15:0] s_address = '0;
    logic [7:0]  s_write_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_read_data;
    logic        m_timer_irq;
    logic        m_bad_address;

    int mismatch_count;
    int results_owed;
    int overflows_seen;
    int idle_cycles = 0;
    int requests_sent = 0;
    int ticks_sent = 0;
    int reads_sent = 0;
    int writes_sent = 0;
    int unused_sent = 0;
    bit no_gaps = 1'b0;

    logic [15:0] timer_regs [4] = '{ADDR_DIV, ADDR_TIMA, ADDR_TMA, ADDR_TAC};

    divider_and_overflow_timer_core #(
        .DIV_PERIOD(DIV_PERIOD)
    ) DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_spent_cycles(s_spent_cycles),
        .s_address     (s_address),
        .s_write_data  (s_write_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_timer_irq   (m_timer_irq),
        .m_bad_address (m_bad_address)
    );

    timer_result_checker #(
        .DIV_PERIOD(DIV_PERIOD)
    ) checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_spent_cycles(s_spent_cycles),
        .s_address     (s_address),
        .s_write_data  (s_write_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_read_data   (m_read_data),
        .m_timer_irq   (m_timer_irq),
        .m_bad_address (m_bad_address),
        .mismatch_count(mismatch_count),
        .results_owed  (results_owed),
        .overflows_seen(overflows_seen)
    );

    // 10 ns clock.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // The receiver stalls at random except during the gap-free stretch.
    always @(negedge aclk) begin
        m_ready <= no_gaps ? 1'b1 : ($urandom_range(0, 99) >= 28);
    end

    // Ends the run when neither channel moves for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $error("No request or result moved for %0d cycles", STALL_LIMIT);
            $display("FAIL divider_and_overflow_timer_core");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Presents one request at a falling edge and holds it until it is taken.
    task automatic issue_request(logic [1:0] req, logic [7:0] cycles, logic [15:0] addr,
                                 logic [7:0] data);
        while (!no_gaps && $urandom_range(0, 99) < 28) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid        = 1'b1;
        s_req_type     = req;
        s_spent_cycles = cycles;
        s_address      = addr;
        s_write_data   = data;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        requests_sent = requests_sent + 1;
        case (req)
            REQ_TICK:  ticks_sent = ticks_sent + 1;
            REQ_READ:  reads_sent = reads_sent + 1;
            REQ_WRITE: writes_sent = writes_sent + 1;
            default:   unused_sent = unused_sent + 1;
        endcase
    endtask

    // Cycle counts favor the two extremes now and then.
    function automatic logic [7:0] pick_cycles();
        case ($urandom_range(0, 9))
            0:       return 8'd0;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] any_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [15:0] any_address();
        return 16'($urandom_range(0, 65535));
    endfunction

    // Arms the timer close to overflow, runs ticks that may carry it through the wrap and reads back.
    task automatic run_overflow_sequence();
        issue_request(REQ_WRITE, any_byte(), ADDR_TMA, any_byte());
        issue_request(REQ_WRITE, any_byte(), ADDR_TIMA, 8'($urandom_range(8'hF0, 8'hFF)));
        issue_request(REQ_WRITE, any_byte(), ADDR_TAC,
                      {5'($urandom_range(0, 31)), 1'b1, 2'($urandom_range(0, 3))});
        repeat ($urandom_range(3, 12)) begin
            if ($urandom_range(0, 4) == 0) begin
                issue_request(REQ_WRITE, any_byte(), ADDR_TMA, any_byte());
            end else begin
                issue_request(REQ_TICK, pick_cycles(), any_address(), any_byte());
            end
        end
        issue_request(REQ_READ, any_byte(), ADDR_TIMA, any_byte());
        issue_request(REQ_READ, any_byte(), ADDR_TMA, any_byte());
    endtask

    // One random request: mostly ticks and register accesses, some noise.
    task automatic issue_random_request();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45) begin
            issue_request(REQ_TICK, pick_cycles(), any_address(), any_byte());
        end else if (pick < 65) begin
            issue_request(REQ_READ, any_byte(), timer_regs[$urandom_range(0, 3)], any_byte());
        end else if (pick < 87) begin
            issue_request(REQ_WRITE, any_byte(), timer_regs[$urandom_range(0, 3)], any_byte());
        end else if (pick < 96) begin
            issue_request(($urandom_range(0, 1) != 0) ? REQ_READ : REQ_WRITE, any_byte(),
                          any_address(), any_byte());
        end else begin
            issue_request(REQ_UNUSED, any_byte(), any_address(), any_byte());
        end
    endtask

    initial begin
        repeat (12) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // Reset values of all four registers.
        issue_request(REQ_READ, 8'h00, ADDR_DIV, 8'h00);
        issue_request(REQ_READ, 8'h00, ADDR_TIMA, 8'h00);
        issue_request(REQ_READ, 8'h00, ADDR_TMA, 8'h00);
        issue_request(REQ_READ, 8'h00, ADDR_TAC, 8'h00);
        // Divider prescaler crossing its period, with empty and full ticks.
        issue_request(REQ_TICK, 8'hFF, 16'h0000, 8'h00);
        issue_request(REQ_TICK, 8'h00, 16'hFFFF, 8'hFF);
        issue_request(REQ_TICK, 8'h02, 16'h0000, 8'h00);
        issue_request(REQ_READ, 8'h00, ADDR_DIV, 8'h00);
        // Control keeps only three bits; read returns them with upper bits zero.
        issue_request(REQ_WRITE, 8'h00, ADDR_TAC, 8'hFF);
        issue_request(REQ_READ, 8'h00, ADDR_TAC, 8'h00);
        // Fastest period, then two modulo writes where the second replaces the first.
        issue_request(REQ_WRITE, 8'h00, ADDR_TAC, 8'h05);
        issue_request(REQ_WRITE, 8'h00, ADDR_TMA, 8'h80);
        issue_request(REQ_WRITE, 8'h00, ADDR_TMA, 8'hA5);
        issue_request(REQ_WRITE, 8'h00, ADDR_TIMA, 8'hFF);
        // Overflow on the tick that also lands the held modulo: reload uses the old one.
        issue_request(REQ_TICK, 8'h10, 16'h0000, 8'h00);
        issue_request(REQ_READ, 8'h00, ADDR_TIMA, 8'h00);
        issue_request(REQ_READ, 8'h00, ADDR_TMA, 8'h00);
        // Divider write clears the count but not the prescaler.
        issue_request(REQ_WRITE, 8'h00, ADDR_DIV, 8'h3C);
        issue_request(REQ_READ, 8'h00, ADDR_DIV, 8'h00);
        // Unknown addresses on both sides of the register block.
        issue_request(REQ_READ, 8'h00, 16'h0000, 8'h00);
        issue_request(REQ_WRITE, 8'h00, 16'hFFFF, 8'hFF);
        issue_request(REQ_READ, 8'h00, 16'hFF08, 8'h00);
        issue_request(REQ_WRITE, 8'h00, 16'hFF03, 8'h55);
        // Undefined request type changes nothing.
        issue_request(REQ_UNUSED, 8'hFF, ADDR_TIMA, 8'hFF);
        issue_request(REQ_READ, 8'h00, ADDR_TIMA, 8'h00);

        // Random part with a gap-free stretch in the middle.
        while (requests_sent < RANDOM_ITEMS + 25) begin
            no_gaps = (requests_sent >= 250) && (requests_sent < 350);
            if ($urandom_range(0, 9) == 0) begin
                run_overflow_sequence();
            end else begin
                issue_random_request();
            end
        end
        no_gaps = 1'b0;
        s_valid = 1'b0;

        // Drain every outstanding result, then let the bench idle before the verdict.
        while (results_owed != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        $display("Sent %0d ticks, %0d reads, %0d writes and %0d undefined requests.",
                 ticks_sent, reads_sent, writes_sent, unused_sent);
        $display("Timer overflows observed: %0d; mismatches: %0d.",
                 overflows_seen, mismatch_count);
        if (mismatch_count == 0) begin
            $display("PASS divider_and_overflow_timer_core");
        end else begin
            $display("FAIL divider_and_overflow_timer_core");
        end
        $finish;
    end

endmodule
